>>> src/tbq_pkg.sv
// shared types, constants and coefficient tables for the three band equalizer
package tbq_pkg;

   localparam int unsigned BANDS        = 3;
   localparam int unsigned MAX_CHANNELS = 8;
   localparam int unsigned CH_W         = 3;
   localparam int unsigned KEY_W        = 5;
   localparam int unsigned RATE_W       = 18;
   localparam int unsigned CNT_W        = 4;
   localparam logic [RATE_W-1:0] LOW_RATE_LIMIT = 18'd16000;

   // register indexes on the csr port
   localparam logic [2:0] REG_RATE   = 3'd0;
   localparam logic [2:0] REG_BOOST  = 3'd1;
   localparam logic [2:0] REG_ENABLE = 3'd2;
   localparam logic [2:0] REG_FORMAT = 3'd3;
   localparam logic [2:0] REG_COUNT  = 3'd4;

   // coefficient slots
   localparam logic [2:0] C_B0 = 3'd0;
   localparam logic [2:0] C_B1 = 3'd1;
   localparam logic [2:0] C_B2 = 3'd2;
   localparam logic [2:0] C_A1 = 3'd3;
   localparam logic [2:0] C_A2 = 3'd4;

   typedef logic signed [31:0] coef_type;

   localparam coef_type TAB_HI [3][5] = '{
      '{32'sd1076322448, -32'sd2120064811, 32'sd1044228161, -32'sd2120135751, 32'sd1046737846},
      '{32'sd1073741824, -32'sd1998672098,  32'sd942176737, -32'sd1998672098,  32'sd942176737},
      '{32'sd1296492709,  -32'sd900434715,  32'sd334711738,  -32'sd583845908,  32'sd240873816}
   };
   localparam coef_type TAB_LO [3][5] = '{
      '{32'sd1081498521, -32'sd2064847259,  32'sd987613154, -32'sd2065469979,  32'sd994747131},
      '{32'sd1073741824, -32'sd1665362810,  32'sd728833892, -32'sd1665362810,  32'sd728833892},
      '{32'sd1239937714,  -32'sd104460284,  32'sd214295730,    32'sd90458879,  32'sd185572456}
   };
   localparam coef_type BOOST_HI [5] = '{
      32'sd1080689931, -32'sd2123605358, 32'sd1043564357, -32'sd2123800651, 32'sd1050317171
   };
   localparam coef_type BOOST_LO [5] = '{
      32'sd1094710047, -32'sd2074729625, 32'sd985735455, -32'sd2076449798, 32'sd1004983505
   };

   function automatic coef_type coef_lookup(input logic low, input logic boost,
                                            input logic [1:0] band, input logic [2:0] slot);
      coef_type c;
      c = '0;
      if (band < 2'd3 && slot < 3'd5) begin
         if (band == 2'd0 && boost)
            c = low ? BOOST_LO[slot] : BOOST_HI[slot];
         else
            c = low ? TAB_LO[band] [slot] : TAB_HI[band][slot];
      end
      return c;
   endfunction

   typedef struct packed {
      logic       accept;
      logic       run;
      logic [1:0] band;
      logic [2:0] phase;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   typedef struct packed {
      logic              low_rate;
      logic              boost;
      logic              format32;
      logic [CNT_W-1:0]  count;
      logic              ch_clear;
   } cfg_type;

endpackage

>>> src/tbq_ctrl.sv
// sequencer: walks bands and multiply phases for one item at a time
module tbq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               enabled,
   input  tbq_pkg::status_type status,
   output tbq_pkg::cmd_type    cmd
);
   import tbq_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_OUT  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [1:0] band_ff, band_in;
   logic [2:0] phase_ff, phase_in;

   always_comb begin
      state_in     = state_ff;
      band_in      = band_ff;
      phase_in     = phase_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.band     = band_ff;
      cmd.phase    = phase_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               band_in    = 2'd0;
               phase_in   = 3'd0;
               state_in   = enabled ? S_RUN : S_OUT;
            end
         end
         S_RUN: begin
            cmd.run = 1'b1;
            if (phase_ff == 3'd5) begin
               phase_in = 3'd0;
               band_in  = band_ff + 2'd1;
               if (band_ff == 2'(BANDS - 1)) state_in = S_OUT;
            end else begin
               phase_in = phase_ff + 3'd1;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         band_ff  <= '0;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         band_ff  <= band_in;
         phase_ff <= phase_in;
      end
   end

endmodule

>>> src/tbq_datapath.sv
// datapath: shared multiplier, delay store, channel tracking and output register
module tbq_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  tbq_pkg::cmd_type     cmd,
   input  tbq_pkg::cfg_type     cfg,
   output tbq_pkg::status_type  status,
   input  logic [31:0]          req_tdata,
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,
   output logic [2:0]           rsp_tuser,
   output logic                 rsp_tlast
);
   import tbq_pkg::*;

   logic [63:0] d1_ff [BANDS*MAX_CHANNELS];
   logic [63:0] d2_ff [BANDS*MAX_CHANNELS];

   logic [CH_W-1:0]     cur_ff;
   logic [CH_W-1:0]     ch_ff;
   logic                bend_ff;
   logic signed [31:0]  val_ff;
   logic signed [33:0]  yn_ff;
   logic [63:0]         prod_ff;
   logic [63:0]         acc_ff;
   logic                valid_ff;
   logic [31:0]         out_data_ff;
   logic [2:0]          out_user_ff;
   logic                out_last_ff;

   logic [CNT_W-1:0]    n_act;
   logic [CH_W-1:0]     ch_now;
   logic [CNT_W-1:0]    ch_next;
   logic signed [31:0]  x_in;
   logic [KEY_W-1:0]    key;
   logic [2:0]          slot;
   coef_type            coef;
   logic signed [33:0]  mul_b;
   logic signed [65:0]  mul_p;
   logic [63:0]         sum_y;
   logic signed [63:0]  sum_ys;
   logic signed [31:0]  yn_sat;

   always_comb begin
      n_act = cfg.count;
      if (n_act == '0) n_act = CNT_W'(1);
      if (n_act > CNT_W'(MAX_CHANNELS)) n_act = CNT_W'(MAX_CHANNELS);
      ch_now  = ({1'b0, cur_ff} >= n_act) ? '0 : cur_ff;
      ch_next = {1'b0, ch_now} + CNT_W'(1);
      x_in    = cfg.format32 ? $signed(req_tdata)
                             : {{16{req_tdata[15]}}, req_tdata[15:0]};
   end

   // multiply phase schedule: b0*x, b1*x, a1*y, b2*x, a2*y
   always_comb begin
      unique case (cmd.phase)
         3'd0:    slot = C_B0;
         3'd1:    slot = C_B1;
         3'd2:    slot = C_A1;
         3'd3:    slot = C_B2;
         3'd4:    slot = C_A2;
         default: slot = C_B0;
      endcase
      coef  = coef_lookup(cfg.low_rate, cfg.boost, cmd.band, slot);
      mul_b = (cmd.phase == 3'd2 || cmd.phase == 3'd4) ? yn_ff : 34'(val_ff);
      mul_p = coef * mul_b;
      key   = KEY_W'({cmd.band, 3'b000}) + KEY_W'(ch_ff);
      sum_y  = prod_ff + d1_ff[key];
      sum_ys = $signed(sum_y) >>> 30;
      if (yn_ff[33:31] == 3'b000 || yn_ff[33:31] == 3'b111)
         yn_sat = yn_ff[31:0];
      else
         yn_sat = yn_ff[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
   end

   assign status.out_free = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= '0;
         valid_ff <= 1'b0;
         for (int i = 0; i < BANDS*MAX_CHANNELS; i++) begin
            d1_ff[i] <= '0;
            d2_ff[i] <= '0;
         end
      end else begin
         if (cfg.ch_clear) cur_ff <= '0;
         if (cmd.accept) begin
            ch_ff   <= ch_now;
            bend_ff <= req_tlast;
            val_ff  <= cfg.format32 ? x_in : {x_in[15:0], 16'h0000};
            cur_ff  <= (req_tlast || ch_next >= n_act) ? '0 : ch_next[CH_W-1:0];
         end
         if (cmd.run) begin
            if (cmd.phase != 3'd5) prod_ff <= mul_p[63:0];
            unique case (cmd.phase)
               3'd1: yn_ff <= sum_ys[33:0];
               3'd2: acc_ff <= prod_ff + d2_ff[key];
               3'd3: acc_ff <= acc_ff - prod_ff;
               3'd4: begin
                  d1_ff[key] <= acc_ff;
                  acc_ff     <= prod_ff;
               end
               3'd5: begin
                  d2_ff[key] <= acc_ff - prod_ff;
                  val_ff     <= yn_sat;
               end
               default: ;
            endcase
         end
         if (cmd.out_load) begin
            valid_ff    <= 1'b1;
            out_data_ff <= cfg.format32 ? val_ff : {{16{val_ff[31]}}, val_ff[31:16]};
            out_user_ff <= ch_ff;
            out_last_ff <= bend_ff;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

>>> src/three_band_biquad_equalizer.sv
// top level of the three band cascaded biquad equalizer
// an item is accepted, runs through every band's multiply phases on the one shared
// multiplier, then is loaded into the output register; when bypassed it goes straight to the
// output load. No new item is taken until the result is loaded, and a stalled output holds it.
// reset: synchronous, clears all delay terms, channel counter, output valid and config registers to defaults
module three_band_biquad_equalizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample_in[31:0]
   input  logic        req_tlast,   // block_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // sample_out[31:0]
   output logic [2:0]  rsp_tuser,   // channel_index[2:0]
   output logic        rsp_tlast,   // block_end_out
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [17:0] csr_wdata
);
   import tbq_pkg::*;

   // configuration registers
   logic [RATE_W-1:0] rate_ff;
   logic              boost_ff;
   logic              enable_ff;
   logic              format_ff;
   logic [CNT_W-1:0]  count_ff;

   cmd_type    cmd;
   status_type status;
   cfg_type    cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= 18'd48000;
         boost_ff  <= 1'b0;
         enable_ff <= 1'b1;
         format_ff <= 1'b1;
         count_ff  <= CNT_W'(2);
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_RATE:   rate_ff   <= csr_wdata;
            REG_BOOST:  boost_ff  <= csr_wdata[0];
            REG_ENABLE: enable_ff <= csr_wdata[0];
            REG_FORMAT: format_ff <= csr_wdata[0];
            REG_COUNT:  count_ff  <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // a channel count write realigns the interleave to channel zero
   always_comb begin
      cfg.low_rate = (rate_ff <= LOW_RATE_LIMIT);
      cfg.boost    = boost_ff;
      cfg.format32 = format_ff;
      cfg.count    = count_ff;
      cfg.ch_clear = csr_we && (csr_addr == REG_COUNT);
   end

   tbq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .enabled    (enable_ff),
      .status     (status),
      .cmd        (cmd)
   );

   tbq_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> src/tbq_checker.sv
// port-level checks for the equalizer, bound to the top level
module tbq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // one item in flight: no back to back accepts
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken twice in a row");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result dropped or changed");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // a result only appears right after the input side was closed
   a_rise_after_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared while input side was open");

endmodule

bind three_band_biquad_equalizer tbq_checker u_tbq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
